// File: src/vra_pkg.sv
// ----------------------------------------------------------------------------
// vra_pkg
// Shared constants and fixed-point helpers for the axis-angle rotator.
// ----------------------------------------------------------------------------
package vra_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ROT_WIDTH       = 32;
    localparam int ANGLE_FRAC_BITS = 28;

    // pipeline depths of the sub-units
    localparam int L_ISQ      = 32;
    localparam int SER_STEPS  = 10;
    localparam int L_TRIG     = 3 * SER_STEPS + 6;
    localparam int DIV_QBITS  = 31;
    localparam int L_DIV      = DIV_QBITS + 2;
    localparam int RECIP_SHIFT = 34;

    localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C235;
    // 2*pi and pi in the half-angle format (ANGLE_FRAC_BITS+1 fraction bits)
    localparam logic [63:0] TWO_PI_A = ((PI_Q62 >> (59 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;
    localparam logic [63:0] PI_A     = ((PI_Q62 >> (60 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;
    localparam int X_SHIFT = 30 - ANGLE_FRAC_BITS - 1;

    localparam logic signed [33:0] Q_ONE       = 34'sd1 <<< 30;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    // Q30 product, rounded half up
    function automatic logic signed [33:0] mq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
        logic signed [67:0] ea;
        logic signed [67:0] eb;
        logic signed [67:0] p;
        ea = a;
        eb = b;
        p  = ea * eb + (68'sd1 <<< 29);
        return p[63:30];
    endfunction

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    // quotient estimate by reciprocal, low by at most one
    function automatic logic [33:0] recip_q(input logic [33:0] m, input logic [33:0] r);
        logic [67:0] p;
        p = 68'(m) * 68'(r);
        return p[RECIP_SHIFT+33:RECIP_SHIFT];
    endfunction

    // corrected truncating quotient, then one series step: 1 - q
    function automatic logic signed [33:0] ser_next(input logic [33:0] mag,
                                                    input logic [33:0] q0,
                                                    input logic neg,
                                                    input logic [9:0] d);
        logic [43:0] rem;
        logic [33:0] q;
        logic signed [33:0] sq;
        rem = 44'(mag) - 44'(q0) * 44'(d);
        q   = (rem >= 44'(d)) ? q0 + 34'd1 : q0;
        sq  = neg ? -$signed(q) : $signed(q);
        return Q_ONE - sq;
    endfunction

endpackage

// File: src/vra_isqrt.sv
// ----------------------------------------------------------------------------
// vra_isqrt
// Pipelined integer square root of a 64-bit word, one result bit per stage.
// ----------------------------------------------------------------------------
module vra_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int L = vra_pkg::L_ISQ;

    logic [63:0] r_n   [L-1];
    logic [63:0] r_res [L];

    for (genvar g = 0; g < L; g++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2 * (L - 1 - g));
        logic [63:0] n_in;
        logic [63:0] res_in;
        logic        take;

        if (g == 0) begin : g_first
            assign n_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign n_in   = r_n[g-1];
            assign res_in = r_res[g-1];
        end

        assign take = n_in >= res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[g] <= take ? (res_in >> 1) + BIT : res_in >> 1;
            end
        end

        if (g < L - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[g] <= take ? n_in - (res_in + BIT) : n_in;
                end
            end
        end
    end

    assign o_root = r_res[L-1][31:0];

endmodule

// File: src/vra_trig.sv
// ----------------------------------------------------------------------------
// vra_trig
// Half-angle reduction and pipelined Taylor series for sine and cosine (Q30).
// ----------------------------------------------------------------------------
module vra_trig (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_ang,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int S  = vra_pkg::SER_STEPS;
    localparam int XD = 3 * S + 1;

    logic [31:0]        r_hr;
    logic signed [33:0] r_x;
    logic signed [31:0] r_xr;
    logic               r_flip;
    logic signed [33:0] r_y;
    logic signed [31:0] r_xd   [XD];
    logic               r_fd   [XD];

    logic signed [33:0] r_ms [S];
    logic signed [33:0] r_mc [S];
    logic signed [33:0] r_ya [S];
    logic [33:0]        r_as [S];
    logic [33:0]        r_ac [S];
    logic               r_ns [S];
    logic               r_nc [S];
    logic [33:0]        r_qs [S];
    logic [33:0]        r_qc [S];
    logic signed [33:0] r_yb [S];
    logic signed [33:0] r_ts [S];
    logic signed [33:0] r_tc [S];
    logic signed [33:0] r_yc [S-1];

    logic signed [33:0] r_sn;
    logic signed [33:0] r_cs;
    logic               r_fe;

    logic [31:0]        n_hr;
    logic signed [33:0] n_h;
    logic signed [31:0] n_xr;
    logic               n_flip;

    always_comb begin
        n_hr = ({32'd0, i_ang} >= vra_pkg::TWO_PI_A)
             ? 32'({32'd0, i_ang} - vra_pkg::TWO_PI_A) : i_ang;
        n_h  = ({32'd0, r_hr} > vra_pkg::PI_A)
             ? $signed({2'b00, r_hr}) - $signed(vra_pkg::TWO_PI_A[33:0])
             : $signed({2'b00, r_hr});
        n_flip = 1'b1;
        if (r_x > vra_pkg::HALF_PI_Q30) begin
            n_xr = 32'(r_x - vra_pkg::PI_Q30);
        end else if (r_x < -vra_pkg::HALF_PI_Q30) begin
            n_xr = 32'(r_x + vra_pkg::PI_Q30);
        end else begin
            n_xr   = r_x[31:0];
            n_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hr   <= n_hr;
            r_x    <= n_h <<< vra_pkg::X_SHIFT;
            r_xr   <= n_xr;
            r_flip <= n_flip;
            r_y    <= vra_pkg::mq({{2{r_xr[31]}}, r_xr}, {{2{r_xr[31]}}, r_xr});
            r_xd[0] <= r_xr;
            r_fd[0] <= r_flip;
            for (int k = 1; k < XD; k++) begin
                r_xd[k] <= r_xd[k-1];
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    for (genvar g = 0; g < S; g++) begin : g_ser
        localparam int K = S - g;
        localparam logic [9:0]  DS = 10'(2 * K * (2 * K + 1));
        localparam logic [9:0]  DC = 10'((2 * K - 1) * 2 * K);
        localparam logic [33:0] MS = 34'((64'd1 << vra_pkg::RECIP_SHIFT) / 64'(DS));
        localparam logic [33:0] MC = 34'((64'd1 << vra_pkg::RECIP_SHIFT) / 64'(DC));
        logic signed [33:0] ts_in;
        logic signed [33:0] tc_in;
        logic signed [33:0] y_in;

        if (g == 0) begin : g_first
            assign ts_in = vra_pkg::Q_ONE;
            assign tc_in = vra_pkg::Q_ONE;
            assign y_in  = r_y;
        end else begin : g_next
            assign ts_in = r_ts[g-1];
            assign tc_in = r_tc[g-1];
            assign y_in  = r_yc[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ms[g] <= vra_pkg::mq(ts_in, y_in);
                r_mc[g] <= vra_pkg::mq(tc_in, y_in);
                r_ya[g] <= y_in;
                r_as[g] <= vra_pkg::mag34(r_ms[g]);
                r_ac[g] <= vra_pkg::mag34(r_mc[g]);
                r_ns[g] <= r_ms[g][33];
                r_nc[g] <= r_mc[g][33];
                r_qs[g] <= vra_pkg::recip_q(vra_pkg::mag34(r_ms[g]), MS);
                r_qc[g] <= vra_pkg::recip_q(vra_pkg::mag34(r_mc[g]), MC);
                r_yb[g] <= r_ya[g];
                r_ts[g] <= vra_pkg::ser_next(r_as[g], r_qs[g], r_ns[g], DS);
                r_tc[g] <= vra_pkg::ser_next(r_ac[g], r_qc[g], r_nc[g], DC);
            end
        end

        if (g < S - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_yc[g] <= r_yb[g];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sn  <= vra_pkg::mq({{2{r_xd[XD-1][31]}}, r_xd[XD-1]}, r_ts[S-1]);
            r_cs  <= r_tc[S-1];
            r_fe  <= r_fd[XD-1];
            o_sin <= r_fe ? 32'(-r_sn) : r_sn[31:0];
            o_cos <= r_fe ? 32'(-r_cs) : r_cs[31:0];
        end
    end

endmodule

// File: src/vra_div.sv
// ----------------------------------------------------------------------------
// vra_div
// Pipelined signed divide by the rotation length, truncating toward zero.
// ----------------------------------------------------------------------------
module vra_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [62:0] i_num,
    input  logic [31:0]        i_den,
    output logic signed [31:0] o_quo
);

    localparam int QB = vra_pkg::DIV_QBITS;

    logic [31:0]    r_rem0;
    logic [QB-1:0]  r_low0;
    logic [31:0]    r_den0;
    logic           r_neg0;
    logic           r_zr0;

    logic [31:0]    r_rem [QB-1];
    logic [QB-1:0]  r_low [QB-1];
    logic [31:0]    r_dv  [QB-1];
    logic [QB-1:0]  r_quo [QB];
    logic           r_ng  [QB];
    logic           r_zr  [QB];

    logic [62:0]    n_mag;

    assign n_mag = i_num[62] ? 63'(-i_num) : 63'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= 32'(n_mag[61:QB]);
            r_low0 <= n_mag[QB-1:0];
            r_den0 <= i_den;
            r_neg0 <= i_num[62];
            r_zr0  <= i_den == '0;
        end
    end

    for (genvar g = 0; g < QB; g++) begin : g_step
        logic [31:0]   rem_in;
        logic [QB-1:0] low_in;
        logic [QB-1:0] quo_in;
        logic [31:0]   den_in;
        logic          neg_in;
        logic          zr_in;
        logic [32:0]   rt;
        logic          ge;

        if (g == 0) begin : g_first
            assign rem_in = r_rem0;
            assign low_in = r_low0;
            assign quo_in = '0;
            assign den_in = r_den0;
            assign neg_in = r_neg0;
            assign zr_in  = r_zr0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign low_in = r_low[g-1];
            assign quo_in = r_quo[g-1];
            assign den_in = r_dv[g-1];
            assign neg_in = r_ng[g-1];
            assign zr_in  = r_zr[g-1];
        end

        assign rt = {rem_in, low_in[QB-1]};
        assign ge = rt >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[g] <= {quo_in[QB-2:0], ge};
                r_ng[g]  <= neg_in;
                r_zr[g]  <= zr_in;
            end
        end

        if (g < QB - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= ge ? 32'(rt - {1'b0, den_in}) : rt[31:0];
                    r_low[g] <= {low_in[QB-2:0], 1'b0};
                    r_dv[g]  <= den_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zr[QB-1]) begin
                o_quo <= '0;
            end else if (r_ng[QB-1]) begin
                o_quo <= -$signed({1'b0, r_quo[QB-1]});
            end else begin
                o_quo <= $signed({1'b0, r_quo[QB-1]});
            end
        end
    end

endmodule

// File: src/vector_rotate_axis_angle.sv
// ----------------------------------------------------------------------------
// vector_rotate_axis_angle
// Rotates a Q16.16 point by a Q4.28 rotation vector (axis times angle).
// ----------------------------------------------------------------------------
// One word enters per cycle while the output is not stalled. The pipeline
// stages are 2 for the squared length, 32 for the square root (one root
// bit per stage), 36 for angle reduction and the ten-term sine and cosine
// series (three stages per term), 1 for r*sin, 33 for the divide by the
// length (one quotient bit per stage) and 5 for the rotation matrix, the
// matrix product, rounding and saturation. A stall on the output holds the
// whole pipeline; nothing is dropped or repeated.
module vector_rotate_axis_angle #(
    parameter int COORD_WIDTH = vra_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic signed [vra_pkg::ROT_WIDTH-1:0] i_rot_x,
    input  logic signed [vra_pkg::ROT_WIDTH-1:0] i_rot_y,
    input  logic signed [vra_pkg::ROT_WIDTH-1:0] i_rot_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z
);

    localparam int ST_A   = 2 + vra_pkg::L_ISQ;
    localparam int ST_SC  = ST_A + vra_pkg::L_TRIG;
    localparam int ST_N   = ST_SC + 1;
    localparam int ST_V   = ST_N + vra_pkg::L_DIV;
    localparam int ST_OUT = ST_V + 5;
    localparam int PD     = ST_V + 2;
    localparam int LT     = vra_pkg::L_TRIG;
    localparam int LD     = vra_pkg::L_DIV;
    localparam int RW     = 34;
    localparam int PW     = RW + COORD_WIDTH;
    localparam int AW     = PW + 2;
    localparam int SW     = AW - 30;
    localparam logic signed [SW-1:0] SMAX =
        {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [31:0] COS_ONE = 32'sd1 <<< 30;

    logic w_en;
    logic [ST_OUT-1:0] r_vld;

    logic signed [COORD_WIDTH-1:0] in_p [3];
    logic signed [31:0]            in_r [3];

    logic signed [COORD_WIDTH-1:0] r_p_dly [PD][3];
    logic signed [31:0]            r_r_dly [ST_SC][3];
    logic [31:0]                   r_a_dly [LT+1];
    logic signed [31:0]            r_cs_dly [LD+1];

    logic [62:0]        r_sq [3];
    logic [63:0]        r_sum;
    logic [31:0]        w_a;
    logic signed [31:0] w_sin;
    logic signed [31:0] w_cos;
    logic signed [62:0] r_num [3];
    logic signed [31:0] w_v [3];

    logic signed [33:0] r_vv [6];
    logic signed [33:0] r_cv [3];
    logic signed [33:0] r_cc;
    logic signed [RW-1:0] r_rm [9];
    logic signed [PW-1:0] r_prod [9];
    logic signed [SW-1:0] r_acc [3];
    logic signed [COORD_WIDTH-1:0] r_out [3];

    logic [62:0]          n_sq [3];
    logic signed [62:0]   n_num [3];
    logic signed [RW-1:0] n_rm [9];
    logic signed [PW-1:0] n_prod [9];
    logic signed [SW-1:0] n_acc [3];
    logic signed [COORD_WIDTH-1:0] n_out [3];

    assign w_en       = !r_vld[ST_OUT-1] || i_out_ready;
    assign o_in_ready = w_en;
    assign o_out_valid = r_vld[ST_OUT-1];

    assign in_p[0] = i_point_x;
    assign in_p[1] = i_point_y;
    assign in_p[2] = i_point_z;
    assign in_r[0] = i_rot_x;
    assign in_r[1] = i_rot_y;
    assign in_r[2] = i_rot_z;

    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_OUT-2:0], i_in_valid};
        end
    end

    always_comb begin
        logic signed [63:0] er;
        logic signed [63:0] es;
        logic signed [33:0] d;
        logic signed [PW-1:0] ex;
        logic signed [PW-1:0] ey;
        logic signed [AW-1:0] acc;
        es = w_sin;
        for (int i = 0; i < 3; i++) begin
            er       = in_r[i];
            n_sq[i]  = 63'(er * er);
            er       = r_r_dly[ST_SC-1][i];
            n_num[i] = 63'(er * es);
        end
        d  = r_cc - (r_vv[0] + r_vv[1] + r_vv[2]);
        n_rm[0] = RW'(d + 2 * r_vv[0]);
        n_rm[1] = RW'(2 * r_vv[3] - 2 * r_cv[2]);
        n_rm[2] = RW'(2 * r_vv[4] + 2 * r_cv[1]);
        n_rm[3] = RW'(2 * r_vv[3] + 2 * r_cv[2]);
        n_rm[4] = RW'(d + 2 * r_vv[1]);
        n_rm[5] = RW'(2 * r_vv[5] - 2 * r_cv[0]);
        n_rm[6] = RW'(2 * r_vv[4] - 2 * r_cv[1]);
        n_rm[7] = RW'(2 * r_vv[5] + 2 * r_cv[0]);
        n_rm[8] = RW'(d + 2 * r_vv[2]);
        for (int k = 0; k < 9; k++) begin
            ex = r_rm[k];
            ey = r_p_dly[PD-1][k % 3];
            n_prod[k] = ex * ey;
        end
        for (int i = 0; i < 3; i++) begin
            acc = AW'(r_prod[3*i]) + AW'(r_prod[3*i+1]) + AW'(r_prod[3*i+2])
                + (AW'(1) <<< 29);
            n_acc[i] = SW'(acc >>> 30);
            if (r_acc[i] > SMAX) begin
                n_out[i] = SMAX[COORD_WIDTH-1:0];
            end else if (r_acc[i] < ~SMAX) begin
                n_out[i] = ~SMAX[COORD_WIDTH-1:0];
            end else begin
                n_out[i] = r_acc[i][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq  <= n_sq;
            r_sum <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_p_dly[0] <= in_p;
            for (int k = 1; k < PD; k++) begin
                r_p_dly[k] <= r_p_dly[k-1];
            end
            r_r_dly[0] <= in_r;
            for (int k = 1; k < ST_SC; k++) begin
                r_r_dly[k] <= r_r_dly[k-1];
            end
            r_a_dly[0] <= w_a;
            for (int k = 1; k <= LT; k++) begin
                r_a_dly[k] <= r_a_dly[k-1];
            end
            r_cs_dly[0] <= w_cos;
            for (int k = 1; k <= LD; k++) begin
                r_cs_dly[k] <= r_cs_dly[k-1];
            end
            r_num <= n_num;
            r_vv[0] <= vra_pkg::mq(34'(w_v[0]), 34'(w_v[0]));
            r_vv[1] <= vra_pkg::mq(34'(w_v[1]), 34'(w_v[1]));
            r_vv[2] <= vra_pkg::mq(34'(w_v[2]), 34'(w_v[2]));
            r_vv[3] <= vra_pkg::mq(34'(w_v[0]), 34'(w_v[1]));
            r_vv[4] <= vra_pkg::mq(34'(w_v[0]), 34'(w_v[2]));
            r_vv[5] <= vra_pkg::mq(34'(w_v[1]), 34'(w_v[2]));
            for (int i = 0; i < 3; i++) begin
                r_cv[i] <= vra_pkg::mq(34'(r_cs_dly[LD]), 34'(w_v[i]));
            end
            r_cc   <= vra_pkg::mq(34'(r_cs_dly[LD]), 34'(r_cs_dly[LD]));
            r_rm   <= n_rm;
            r_prod <= n_prod;
            r_acc  <= n_acc;
            r_out  <= n_out;
        end
    end

    vra_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sum),
        .o_root (w_a)
    );

    vra_trig u_trig (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (w_a),
        .o_sin (w_sin),
        .o_cos (w_cos)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        vra_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num[i]),
            .i_den (r_a_dly[LT]),
            .o_quo (w_v[i])
        );
    end

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld == $past(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_SC-1] |-> (w_cos <= COS_ONE && w_cos >= -COS_ONE))
        else $error("cosine outside unit range");

    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_SC-1] && r_a_dly[LT-1] == '0) |-> (w_sin == '0 && w_cos == COS_ONE))
        else $error("zero rotation gave non-identity sine or cosine");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for vector_rotate_axis_angle: a directed table of points and
// rotation vectors (zero rotation, extremes, wrapping angles, saturation)
// followed by random words with random idling on both sides. Every output
// word is compared with its table entry or a rotation computed in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 32;
    localparam int N_RANDOM  = 1900;
    localparam int TAIL_CYC  = 200;

    typedef struct {
        logic signed [CW-1:0] px, py, pz;
        logic signed [31:0]   rx, ry, rz;
        bit                   has_exp;
        logic signed [CW-1:0] ex, ey, ez;
    } t_rot_row;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
    } t_coord;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_point_x, i_point_y, i_point_z;
    logic signed [31:0]   i_rot_x, i_rot_y, i_rot_z;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [CW-1:0] o_out_x, o_out_y, o_out_z;

    t_coord  rotated_q[$];
    int      n_fail;
    bit      stim_done;

    vector_rotate_axis_angle #(.COORD_WIDTH(CW)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_rot_x(i_rot_x), .i_rot_y(i_rot_y), .i_rot_z(i_rot_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("vector_rotate_axis_angle regression: fail");
        $finish;
    end

    // Q30 product, half up
    function automatic longint q30_mul(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b)) + (128'sd1 <<< 29);
        return longint'(p >>> 30);
    endfunction

    function automatic logic [63:0] isqrt_u64(logic [63:0] n);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] row_dot(longint m0, longint m1, longint m2,
                                                     longint p0, longint p1, longint p2);
        logic signed [127:0] acc, sh, maxw, minw;
        acc = (128'sd1 <<< 29) + 128'(signed'(m0)) * 128'(signed'(p0))
            + 128'(signed'(m1)) * 128'(signed'(p1)) + 128'(signed'(m2)) * 128'(signed'(p2));
        sh   = acc >>> 30;
        maxw = (128'sd1 <<< (CW - 1)) - 1;
        minw = -(128'sd1 <<< (CW - 1));
        if (sh > maxw) sh = maxw;
        if (sh < minw) sh = minw;
        return sh[CW-1:0];
    endfunction

    function automatic t_coord rotate_point(t_rot_row w);
        localparam logic [63:0] PI62 = 64'hC90FDAA22168C235;
        localparam longint PI30  = 64'hC90FDAA2;
        localparam longint HPI30 = 64'h6487ED51;
        longint p[3], r[3], v[3], m[9];
        logic [63:0] sum, a, twopi, pih, hr, mg;
        longint h, x, y, ts, tc, sn, cs, ss, d;
        bit flip;
        t_coord o;
        p[0] = w.px; p[1] = w.py; p[2] = w.pz;
        r[0] = w.rx; r[1] = w.ry; r[2] = w.rz;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mg  = r[i] < 0 ? 64'(-r[i]) : 64'(r[i]);
            sum = sum + mg * mg;
        end
        a     = isqrt_u64(sum);
        twopi = ((PI62 >> (59 - 28)) + 1) >> 1;
        pih   = ((PI62 >> (60 - 28)) + 1) >> 1;
        hr    = a % twopi;
        h     = hr > pih ? -longint'(twopi - hr) : longint'(hr);
        x     = h * 2;
        flip  = 0;
        if (x > HPI30) begin
            x = x - PI30; flip = 1;
        end else if (x < -HPI30) begin
            x = x + PI30; flip = 1;
        end
        y  = q30_mul(x, x);
        ts = 64'd1 << 30;
        tc = 64'd1 << 30;
        for (int k = 10; k >= 1; k--) begin
            ts = (64'd1 << 30) - q30_mul(ts, y) / longint'((2 * k) * (2 * k + 1));
            tc = (64'd1 << 30) - q30_mul(tc, y) / longint'((2 * k - 1) * (2 * k));
        end
        sn = q30_mul(x, ts);
        cs = tc;
        if (flip) begin
            sn = -sn; cs = -cs;
        end
        for (int i = 0; i < 3; i++) v[i] = (a == 0) ? 0 : (r[i] * sn) / longint'(a);
        ss = q30_mul(cs, cs);
        d  = ss - (q30_mul(v[0], v[0]) + q30_mul(v[1], v[1]) + q30_mul(v[2], v[2]));
        m[0] = d + 2 * q30_mul(v[0], v[0]);
        m[1] = 2 * q30_mul(v[0], v[1]) - 2 * q30_mul(cs, v[2]);
        m[2] = 2 * q30_mul(v[0], v[2]) + 2 * q30_mul(cs, v[1]);
        m[3] = 2 * q30_mul(v[1], v[0]) + 2 * q30_mul(cs, v[2]);
        m[4] = d + 2 * q30_mul(v[1], v[1]);
        m[5] = 2 * q30_mul(v[1], v[2]) - 2 * q30_mul(cs, v[0]);
        m[6] = 2 * q30_mul(v[2], v[0]) - 2 * q30_mul(cs, v[1]);
        m[7] = 2 * q30_mul(v[2], v[1]) + 2 * q30_mul(cs, v[0]);
        m[8] = d + 2 * q30_mul(v[2], v[2]);
        o.x = row_dot(m[0], m[1], m[2], p[0], p[1], p[2]);
        o.y = row_dot(m[3], m[4], m[5], p[0], p[1], p[2]);
        o.z = row_dot(m[6], m[7], m[8], p[0], p[1], p[2]);
        return o;
    endfunction

    function automatic t_rot_row mk_row(int px, int py, int pz, int rx, int ry, int rz,
                                        bit he, int ex, int ey, int ez);
        t_rot_row w;
        w.px = px; w.py = py; w.pz = pz;
        w.rx = rx; w.ry = ry; w.rz = rz;
        w.has_exp = he; w.ex = ex; w.ey = ey; w.ez = ez;
        return w;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh0007FFFF;
            2:       return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                                 : 32'h80000000 + $urandom_range(0, 255);
            default: return $signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh07FFFFFF;
        endcase
    endfunction

    function automatic int rand_rot();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 0;
            2:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $signed($urandom_range(0, 32'h3FFFFFFF)) - 32'sh1FFFFFFF;
        endcase
    endfunction

    // valid stays high after the handshake; an idle gap or the caller drops it
    task automatic send_word(t_rot_row w);
        int gap;
        t_coord e;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x <= w.px; i_point_y <= w.py; i_point_z <= w.pz;
        i_rot_x <= w.rx; i_rot_y <= w.ry; i_rot_z <= w.rz;
        do @(posedge i_clk); while (!o_in_ready);
        if (w.has_exp) begin
            e.x = w.ex; e.y = w.ey; e.z = w.ez;
        end else begin
            e = rotate_point(w);
        end
        rotated_q.push_back(e);
    endtask

    // output side: random stall, compare on handshake
    initial begin
        int stall;
        t_coord e;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                if (rotated_q.size() == 0) begin
                    $error("out word with nothing expected");
                    n_fail++;
                end else begin
                    e = rotated_q.pop_front();
                    if (o_out_x !== e.x) begin
                        $error("out_x exp %0d got %0d", e.x, o_out_x); n_fail++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y exp %0d got %0d", e.y, o_out_y); n_fail++;
                    end
                    if (o_out_z !== e.z) begin
                        $error("out_z exp %0d got %0d", e.z, o_out_z); n_fail++;
                    end
                end
                stall = stim_done ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0) stall = 0;
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
            end else if (!i_out_ready) begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_rot_row table_q[$];
        t_rot_row w;
        int wait_cyc;
        n_fail = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_point_x = 0; i_point_y = 0; i_point_z = 0;
        i_rot_x = 0; i_rot_y = 0; i_rot_z = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero rotation passes the point unchanged; a zero point stays zero
        table_q.push_back(mk_row(32'h00010000, -32'sh00020000, 32'h00030000, 0, 0, 0,
                                 1, 32'h00010000, -32'sh00020000, 32'h00030000));
        table_q.push_back(mk_row(32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0,
                                 1, 32'h7FFFFFFF, 32'h80000000, 0));
        table_q.push_back(mk_row(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0,
                                 1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF));
        table_q.push_back(mk_row(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h12345678,
                                 1, 0, 0, 0));
        // quarter turns, half turns, wrap and saturation via predictor
        table_q.push_back(mk_row(32'h00010000, 0, 0, 0, 0, 32'h1921FB54, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h00010000, 0, 0, 0, 0, 32'h3243F6A9, 0, 0, 0, 0));
        table_q.push_back(mk_row(0, 32'h00010000, 0, 32'h3243F6A9, 0, 0, 0, 0, 0, 0));
        table_q.push_back(mk_row(0, 0, 32'h00010000, 0, -32'sh3243F6A9, 0, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h00010000, 32'h00010000, 32'h00010000,
                                 32'h6487ED51, 0, 0, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 32'h1921FB54, 32'h1921FB54, 32'h1921FB54, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h12345678, -32'sh0ABCDEF0, 32'h00000001,
                                 1, 0, 0, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h00010000, 32'h00020000, 32'h00030000,
                                 -1, -1, -1, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h00010000, 0, 0, 0, 0, 32'h6487ED51, 0, 0, 0, 0));
        table_q.push_back(mk_row(32'h7FFFFFFF, 0, 0, 0, 0, 32'h3243F6A9, 0, 0, 0, 0));

        foreach (table_q[i]) send_word(table_q[i]);

        // hold off until everything has drained
        i_in_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            w = mk_row(rand_coord(), rand_coord(), rand_coord(),
                       rand_rot(), rand_rot(), rand_rot(), 0, 0, 0, 0);
            send_word(w);
            if (n == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                while (rotated_q.size() != 0) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        stim_done = 1;

        wait_cyc = 0;
        while (rotated_q.size() != 0 && wait_cyc < 100000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (TAIL_CYC) @(posedge i_clk);
        if (rotated_q.size() != 0) begin
            $error("%0d words never came out", rotated_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("vector_rotate_axis_angle regression: pass");
        end else begin
            $display("vector_rotate_axis_angle regression: fail");
        end
        $finish;
    end
endmodule
